>>> rtl/core/aes_pkg.sv
`timescale 1ns / 1ps

package aes_pkg;

  typedef logic [7:0] sbox_tab_t [256];

  localparam sbox_tab_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // inverse table derived from the forward one at elaboration
  function automatic sbox_tab_t build_inv();
    sbox_tab_t t;
    for (int v = 0; v < 256; v++) begin
      t[SBOX[v]] = v[7:0];
    end
    return t;
  endfunction

  localparam sbox_tab_t INV_SBOX = build_inv();

  typedef enum logic [2:0] {
    REG_KEY_LENGTH = 3'd0,
    REG_KEY_WORD0  = 3'd1,
    REG_KEY_WORD1  = 3'd2,
    REG_KEY_WORD2  = 3'd3,
    REG_KEY_WORD3  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_FETCH,
    S_ROUND,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;      // latch block and direction
    logic exp_init;  // restart key schedule
    logic exp_step;  // produce one schedule word
    logic fetch;     // read first round key
    logic round;     // run one round step
  } dp_cmd_t;

  typedef struct packed {
    logic keys_ready;
    logic exp_last;
    logic last_step;
  } dp_stat_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // forward or inverse SubBytes + ShiftRows
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   b;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          b = s[127 - 8 * ((((c - r) & 3) * 4) + r) -: 8];
          t[127 - 8 * (c * 4 + r) -: 8] = INV_SBOX[b];
        end else begin
          b = s[127 - 8 * ((((c + r) & 3) * 4) + r) -: 8];
          t[127 - 8 * (c * 4 + r) -: 8] = SBOX[b];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   m3 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   m11 [4];
    logic [7:0]   m13 [4];
    logic [7:0]   m14 [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]   = s[127 - 8 * (c * 4 + k) -: 8];
        x2[k]  = xt(a[k]);
        x4[k]  = xt(x2[k]);
        x8[k]  = xt(x4[k]);
        m3[k]  = x2[k] ^ a[k];
        m9[k]  = x8[k] ^ a[k];
        m11[k] = x8[k] ^ x2[k] ^ a[k];
        m13[k] = x8[k] ^ x4[k] ^ a[k];
        m14[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8 * (c * 4 + r) -: 8] = m14[r] ^ m11[(r + 1) & 3] ^
                                          m13[(r + 2) & 3] ^ m9[(r + 3) & 3];
        end else begin
          t[127 - 8 * (c * 4 + r) -: 8] = x2[r] ^ m3[(r + 1) & 3] ^
                                          a[(r + 2) & 3] ^ a[(r + 3) & 3];
        end
      end
    end
    return t;
  endfunction

endpackage

>>> rtl/core/aes_ctrl.sv
`timescale 1ns / 1ps

module aes_ctrl
  import aes_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        // a config write takes the cycle; the block waits while cfg_valid is high
        in_stall  = cfg_valid;
        cfg_ready = 1'b1;
        if (in_valid && !cfg_valid) begin
          cmd.load = 1'b1;
          if (stat.keys_ready) begin
            state_next = S_FETCH;
          end else begin
            cmd.exp_init = 1'b1;
            state_next   = S_EXPAND;
          end
        end
      end
      S_EXPAND: begin
        cmd.exp_step = 1'b1;
        if (stat.exp_last) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_step) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/aes_datapath.sv
`timescale 1ns / 1ps

module aes_datapath
  import aes_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          command,
  input  logic [63:0]   block_high,
  input  logic [63:0]   block_low,
  output logic [127:0]  result
);

  logic [1:0]   key_length;
  logic [63:0]  key_word [4];
  logic         keys_ready;

  logic [127:0] rk_mem [15];
  logic [127:0] rk_q;

  logic [127:0] st;
  logic         dec;
  logic [3:0]   step;

  logic [5:0]   widx;
  logic [2:0]   pos;
  logic [7:0]   rcon;
  logic [31:0]  win [8];
  logic [95:0]  row_buf;

  logic [3:0]   nr;
  logic [2:0]   nk_m1;
  logic [5:0]   total_m1;
  logic [31:0]  key_w;
  logic [31:0]  tmp;
  logic [31:0]  new_w;
  logic [31:0]  far_w;
  logic         rcon_use;

  always_comb begin
    case (key_length)
      2'd0: begin
        nr    = 4'd10;
        nk_m1 = 3'd3;
      end
      2'd1: begin
        nr    = 4'd12;
        nk_m1 = 3'd5;
      end
      default: begin
        nr    = 4'd14;
        nk_m1 = 3'd7;
      end
    endcase
  end

  assign total_m1 = {nr, 2'b11};

  // key schedule word
  always_comb begin
    key_w    = widx[0] ? key_word[widx[2:1]][31:0] : key_word[widx[2:1]][63:32];
    far_w    = win[nk_m1];
    rcon_use = 1'b0;
    tmp      = win[0];
    if (pos == 3'd0) begin
      tmp      = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'd0};
      rcon_use = 1'b1;
    end else if (nk_m1 == 3'd7 && pos == 3'd4) begin
      tmp = sub_word(win[0]);
    end
    if (widx <= {3'd0, nk_m1}) begin
      new_w    = key_w;
      rcon_use = 1'b0;
    end else begin
      new_w = far_w ^ tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= 2'd0;
      for (int j = 0; j < 4; j++) begin
        key_word[j] <= '0;
      end
      keys_ready <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LENGTH: key_length  <= cfg_data[1:0];
          REG_KEY_WORD0:  key_word[0] <= cfg_data;
          REG_KEY_WORD1:  key_word[1] <= cfg_data;
          REG_KEY_WORD2:  key_word[2] <= cfg_data;
          REG_KEY_WORD3:  key_word[3] <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_KEY_WORD3) begin
          keys_ready <= 1'b0;
        end
      end
      if (cmd.exp_step && widx == total_m1) begin
        keys_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_init) begin
      widx <= '0;
      pos  <= '0;
      rcon <= 8'h01;
    end else if (cmd.exp_step) begin
      widx <= widx + 6'd1;
      pos  <= (pos == nk_m1) ? 3'd0 : pos + 3'd1;
      if (rcon_use) begin
        rcon <= xt(rcon);
      end
      win[0] <= new_w;
      for (int j = 1; j < 8; j++) begin
        win[j] <= win[j - 1];
      end
      row_buf <= {row_buf[63:0], new_w};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step && widx[1:0] == 2'b11) begin
      rk_mem[widx[5:2]] <= {row_buf, new_w};
    end
  end

  // round key read, one row ahead of use
  logic [3:0] step_nx;
  logic [3:0] rd_addr;
  logic       rd_en;
  logic       cur_dec;

  assign step_nx = cmd.fetch ? 4'd0 : step + 4'd1;
  assign cur_dec = cmd.fetch ? dec : dec;
  assign rd_addr = cur_dec ? nr - step_nx : step_nx;
  assign rd_en   = cmd.fetch || (cmd.round && step != nr);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rk_q <= rk_mem[rd_addr];
    end
  end

  logic [127:0] ss;
  logic [127:0] st_next;

  always_comb begin
    ss = sub_shift(st, dec);
    if (step == 4'd0) begin
      st_next = st ^ rk_q;
    end else if (step == nr) begin
      st_next = ss ^ rk_q;
    end else if (dec) begin
      st_next = mix(ss ^ rk_q, 1'b1);
    end else begin
      st_next = mix(ss, 1'b0) ^ rk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st  <= {block_high, block_low};
      dec <= command;
    end else if (cmd.round) begin
      st <= st_next;
    end
    if (cmd.fetch) begin
      step <= 4'd0;
    end else if (cmd.round) begin
      step <= step + 4'd1;
    end
  end

  assign stat.keys_ready = keys_ready;
  assign stat.exp_last   = (widx == total_m1);
  assign stat.last_step  = (step == nr);
  assign result          = st;

endmodule

>>> rtl/core/aes_block_cipher.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_stall    command, block_high, block_low
// output    out_valid / out_stall  result_high, result_low
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One block at a time. A block goes from its transfer through the fetch and
// round states to the result transfer, in the single round unit that runs one
// round a cycle; the next block is taken the cycle after the result leaves.
// The first block after reset or a write to the key length or a key word
// first runs the key schedule, one 32-bit word a cycle.
// rst is synchronous; it clears the key registers and the expanded-key flag.
// A stalled result holds in the state register; no new block is taken until
// it transfers. Config is taken only while idle and wins over a block
// offered in the same cycle.

module aes_block_cipher
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dp_cmd_t      cmd;
  dp_stat_t     stat;
  logic [127:0] result;

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aes_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (command),
    .block_high (block_high),
    .block_low  (block_low),
    .result     (result)
  );

  assign result_high = result[127:64];
  assign result_low  = result[63:0];

  // a block in flight blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while block in flight");

  // pending result never coexists with an open input or config port
  a_out_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (in_stall && !cfg_ready))
    else $error("result pending while idle");

  // result transfers exactly once
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

endmodule
